// ----- sv/khle_pkg.sv -----
// Package for the key heat map LED engine: sizes, codes, structs and the
// key-position-to-LED table. Depends on nothing; used by every module.
package khle_pkg;

	localparam int LED_COUNT = 60;
	localparam int LED_AW    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam int LED_CW    = $clog2(LED_COUNT + 1);
	localparam int ROWS      = 8;
	localparam int COLS      = 6;
	localparam int PADDR_W   = 3;

	localparam logic       ACT_HIT    = 1'b0;
	localparam logic       ACT_FRAME  = 1'b1;
	localparam logic       REG_ENABLE = 1'b0;
	localparam logic       REG_LIMIT  = 1'b1;

	localparam logic [7:0] HIT_MIN    = 8'd5;
	localparam logic [7:0] HUE_COLD   = 8'd169;
	localparam logic [7:0] HEAT_T1    = 8'd75;
	localparam logic [7:0] HEAT_T2    = 8'd117;
	localparam logic [7:0] HEAT_T3    = 8'd159;
	localparam logic [7:0] HEAT_T4    = 8'd245;
	localparam logic [7:0] BRIGHT_HOT = 8'd150;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_KEY_RD,
		ST_KEY_WR,
		ST_SWEEP
	} seq_state_t;

	typedef enum logic {
		ALU_ADD,
		ALU_DEC
	} alu_op_t;

	typedef struct packed {
		logic       action;
		logic [2:0] key_row;
		logic [2:0] key_col;
		logic [7:0] amount;
	} in_item_t;

	typedef struct packed {
		logic [5:0] led_number;
		logic [7:0] hue;
		logic [7:0] brightness;
		logic       last_led;
	} out_item_t;

	typedef struct packed {
		logic              rd_en;
		logic [LED_AW-1:0] rd_addr;
		logic              wr_en;
		logic [LED_AW-1:0] wr_addr;
		logic [7:0]        wr_data;
	} heat_req_t;

	localparam logic [5:0] KEY_LED [ROWS][COLS] = '{
		'{6'd17, 6'd14, 6'd10, 6'd6,  6'd3,  6'd0 },
		'{6'd18, 6'd15, 6'd11, 6'd7,  6'd4,  6'd1 },
		'{6'd19, 6'd16, 6'd12, 6'd8,  6'd5,  6'd2 },
		'{6'd59, 6'd13, 6'd9,  6'd27, 6'd28, 6'd29},
		'{6'd40, 6'd43, 6'd47, 6'd50, 6'd53, 6'd56},
		'{6'd41, 6'd44, 6'd48, 6'd51, 6'd54, 6'd57},
		'{6'd42, 6'd45, 6'd49, 6'd52, 6'd55, 6'd58},
		'{6'd59, 6'd46, 6'd59, 6'd59, 6'd31, 6'd30}
	};

	function automatic logic [5:0] key_led(input logic [2:0] row, input logic [2:0] col);
		logic [2:0] c;
		c = (col < 3'(COLS)) ? col : 3'd0;
		return KEY_LED[row][c];
	endfunction

endpackage

// ----- sv/khle_heat_store.sv -----
// Heat level memory with per-entry valid bits; an unwritten entry reads as zero.
// Depends on khle_pkg.
module khle_heat_store
	import khle_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  heat_req_t req,
	output logic [7:0] rd_level
);

	logic [7:0]           mem_q [LED_COUNT];
	logic [LED_COUNT-1:0] vld_q;
	logic [7:0]           rd_data_q;
	logic                 rd_vld_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem_q[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_q <= vld_q[req.rd_addr];
			end
		end
	end

	assign rd_level = rd_vld_q ? rd_data_q : 8'd0;

endmodule

// ----- sv/khle_heat_alu.sv -----
// Shared saturating heat unit: add an amount, or decay by one.
// Depends on khle_pkg.
module khle_heat_alu
	import khle_pkg::*;
(
	input  alu_op_t    op,
	input  logic [7:0] level,
	input  logic [7:0] operand,
	output logic [7:0] result
);

	logic [8:0] sum;

	assign sum = {1'b0, level} + {1'b0, operand};

	always_comb begin
		unique case (op)
			ALU_ADD: result = sum[8] ? 8'd255 : sum[7:0];
			ALU_DEC: result = (level == 8'd0) ? 8'd0 : level - 8'd1;
			default: result = level;
		endcase
	end

endmodule

// ----- sv/khle_colour_map.sv -----
// Heat-to-colour map: piecewise hue and capped brightness for one heat level.
// Depends on khle_pkg.
module khle_colour_map
	import khle_pkg::*;
(
	input  logic [7:0] heat,
	input  logic [7:0] limit,
	output logic [7:0] hue,
	output logic [7:0] brightness
);

	logic [9:0] steep;
	logic [7:0] gentle;
	logic [7:0] raw_bright;

	assign steep  = 10'd361 - {1'b0, heat, 1'b0};
	assign gentle = heat - HEAT_T3;

	always_comb begin
		priority if (heat < HEAT_T1) begin
			hue = HUE_COLD;
		end else if (heat < HEAT_T2) begin
			hue = 8'd244 - heat;
		end else if (heat < HEAT_T3) begin
			hue = steep[7:0];
		end else if (heat < HEAT_T4) begin
			hue = 8'd43 - {1'b0, gentle[7:1]};
		end else begin
			hue = 8'd0;
		end
	end

	assign raw_bright = (heat < HEAT_T1) ? {heat[6:0], 1'b0} : BRIGHT_HOT;
	assign brightness = (raw_bright > limit) ? limit : raw_bright;

endmodule

// ----- sv/key_heatmap_led_engine.sv -----
// Top level of the key heat map LED engine: sequencer, configuration port and
// result register. Depends on khle_pkg, khle_heat_store, khle_heat_alu, khle_colour_map.
//
// channel   direction  handshake             payload
// in        request    in_valid / in_stall   in_data   (in_item_t)
// out       result     out_valid / out_stall out_data  (out_item_t)
// cfg       APB write  psel/penable/pwrite   paddr, pwdata, prdata
//
// Key hit above the threshold: the key, then each neighbour on its half of the matrix,
// is read from the heat memory and written back with the amount added, halved for a neighbour.
// A hit off the matrix or a disabled frame goes straight back to idle.
// Decay request or enabled frame: every LED is decayed, one LED a cycle through the
// memory read register unless out_stall holds it, which it does for a frame sweep only.
// Reset clears the memory valid bits at once, so all levels read as zero.
module key_heatmap_led_engine
	import khle_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  in_item_t           in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output out_item_t          out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	seq_state_t        state_q, state_nxt;
	logic [2:0]        row_q, col_q, step_q;
	logic [7:0]        amt_q;
	logic              frame_q;
	logic [LED_CW-1:0] rd_idx_q;
	logic              sw_valid_s1;
	logic [LED_AW-1:0] sw_idx_s1;
	logic              enabled_q;
	logic [7:0]        limit_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic              accept, cfg_wr;
	logic [2:0]        tgt_row, tgt_col;
	logic [7:0]        tgt_amt;
	logic              tgt_ok, tgt_hit;
	logic [5:0]        tgt_led;
	logic              sink_ready, advance, sw_more, emit;
	heat_req_t         req;
	alu_op_t           alu_op;
	logic [7:0]        level, alu_res, hue, bright;

	assign accept = in_valid && !in_stall;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b1;
			limit_q   <= 8'd255;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_ENABLE: enabled_q <= pwdata[0];
				REG_LIMIT:  limit_q   <= pwdata[7:0];
				default:    enabled_q <= enabled_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_ENABLE: prdata = {31'd0, enabled_q};
			REG_LIMIT:  prdata = {24'd0, limit_q};
			default:    prdata = 32'd0;
		endcase
	end

	always_comb begin
		tgt_row = row_q;
		tgt_col = col_q;
		tgt_amt = {1'b0, amt_q[7:1]};
		tgt_ok  = 1'b0;
		unique case (step_q)
			3'd0: begin
				tgt_amt = amt_q;
				tgt_ok  = 1'b1;
			end
			3'd1: begin
				tgt_row = row_q - 3'd1;
				tgt_ok  = (row_q != 3'd0) && (row_q != 3'd4);
			end
			3'd2: begin
				tgt_row = row_q + 3'd1;
				tgt_ok  = (row_q != 3'd3) && (row_q != 3'd7);
			end
			3'd3: begin
				tgt_col = col_q - 3'd1;
				tgt_ok  = (col_q != 3'd0);
			end
			3'd4: begin
				tgt_col = col_q + 3'd1;
				tgt_ok  = (col_q != 3'd5);
			end
			default: tgt_ok = 1'b0;
		endcase
	end

	assign tgt_led = key_led(tgt_row, tgt_col);
	assign tgt_hit = tgt_ok && ({1'b0, tgt_led} < 7'(LED_COUNT));

	assign sink_ready = !frame_q || !out_valid_q || !out_stall;
	assign advance    = !sw_valid_s1 || sink_ready;
	assign sw_more    = (rd_idx_q != LED_CW'(LED_COUNT));

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_data.action == ACT_FRAME) begin
						state_nxt = enabled_q ? ST_SWEEP : ST_IDLE;
					end else if (in_data.amount > HIT_MIN) begin
						state_nxt = (in_data.key_col < 3'(COLS)) ? ST_KEY_RD : ST_IDLE;
					end else begin
						state_nxt = ST_SWEEP;
					end
				end
			end
			ST_KEY_RD: begin
				if (tgt_hit) begin
					state_nxt = ST_KEY_WR;
				end else if (step_q == 3'd4) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_KEY_WR: state_nxt = (step_q == 3'd4) ? ST_IDLE : ST_KEY_RD;
			ST_SWEEP:  state_nxt = (advance && !sw_more) ? ST_IDLE : ST_SWEEP;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		req         = '0;
		alu_op      = ALU_DEC;
		emit        = 1'b0;
		in_stall    = 1'b1;
		req.wr_data = alu_res;
		unique case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_KEY_RD: begin
				req.rd_en   = tgt_hit;
				req.rd_addr = tgt_led[LED_AW-1:0];
			end
			ST_KEY_WR: begin
				alu_op      = ALU_ADD;
				req.wr_en   = 1'b1;
				req.wr_addr = tgt_led[LED_AW-1:0];
			end
			ST_SWEEP: begin
				req.rd_en   = advance && sw_more;
				req.rd_addr = rd_idx_q[LED_AW-1:0];
				req.wr_en   = sw_valid_s1 && sink_ready;
				req.wr_addr = sw_idx_s1;
				emit        = sw_valid_s1 && sink_ready && frame_q;
			end
			default: in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= 3'd0;
			frame_q     <= 1'b0;
			rd_idx_q    <= '0;
			sw_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				step_q   <= 3'd0;
				frame_q  <= (in_data.action == ACT_FRAME);
				rd_idx_q <= '0;
			end else if (state_q == ST_KEY_WR
				|| (state_q == ST_KEY_RD && !tgt_hit)) begin
				step_q <= step_q + 3'd1;
			end
			if (state_q == ST_SWEEP && advance) begin
				sw_valid_s1 <= sw_more;
				if (sw_more) begin
					rd_idx_q <= rd_idx_q + LED_CW'(1);
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_q <= in_data.key_row;
			col_q <= in_data.key_col;
			amt_q <= in_data.amount;
		end
		if (state_q == ST_SWEEP && advance && sw_more) begin
			sw_idx_s1 <= rd_idx_q[LED_AW-1:0];
		end
		if (emit) begin
			out_q.led_number <= 6'(sw_idx_s1);
			out_q.hue        <= hue;
			out_q.brightness <= bright;
			out_q.last_led   <= (sw_idx_s1 == LED_AW'(LED_COUNT - 1));
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	khle_heat_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rd_level (level)
	);

	khle_heat_alu u_alu (
		.op      (alu_op),
		.level   (level),
		.operand (tgt_amt),
		.result  (alu_res)
	);

	khle_colour_map u_colour (
		.heat       (level),
		.limit      (limit_q),
		.hue        (hue),
		.brightness (bright)
	);

endmodule

// ----- sv/khle_checker.sv -----
// Port-level checks for the key heat map LED engine, bound to the top level.
// Depends on khle_pkg and key_heatmap_led_engine.
module khle_checker
	import khle_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input in_item_t           in_data,
	input logic               out_valid,
	input logic               out_stall,
	input out_item_t          out_data,
	input logic               psel,
	input logic               penable,
	input logic               pwrite,
	input logic [PADDR_W-1:0] paddr,
	input logic [31:0]        pwdata,
	input logic [31:0]        prdata,
	input logic               pready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_decay_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.action == ACT_HIT && in_data.amount <= HIT_MIN
		|=> in_stall)
		else $error("decay request did not occupy the block");

	a_result_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result raised while idle");

	a_last_led: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.last_led |-> out_data.led_number == 6'(LED_COUNT - 1))
		else $error("last LED flag on wrong LED");

	a_enable_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr[2] == REG_ENABLE
		|=> paddr[2] != REG_ENABLE || prdata[0] == $past(pwdata[0]))
		else $error("enable register read back wrong");

endmodule

bind key_heatmap_led_engine khle_checker u_khle_checker (.*);
